// ===== design/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
// Holds the channel payload structs, the configuration record and register indexes.
// No dependencies; every other design file imports this package.
package bdpc_pkg;

  localparam int TIME_BITS = 32;
  localparam int BDPC_FIFO_DEPTH = 2;

  localparam logic        RST_ENABLE        = 1'b1;
  localparam logic [15:0] RST_STABLE_COUNT  = 16'd20;
  localparam logic [15:0] RST_SAMPLE_WINDOW = 16'd200;
  localparam logic [15:0] RST_CLICK_MIN_MS  = 16'd100;
  localparam logic [15:0] RST_CLICK_MAX_MS  = 16'd500;
  localparam logic [15:0] RST_LONG_MIN_MS   = 16'd2000;
  localparam logic [15:0] RST_HOLD_LIMIT_MS = 16'd5000;

  typedef enum logic [2:0] {
    CFG_ENABLE        = 3'd0,
    CFG_STABLE_COUNT  = 3'd1,
    CFG_SAMPLE_WINDOW = 3'd2,
    CFG_CLICK_MIN_MS  = 3'd3,
    CFG_CLICK_MAX_MS  = 3'd4,
    CFG_LONG_MIN_MS   = 3'd5,
    CFG_HOLD_LIMIT_MS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        pin_level;
    logic        window_start;
    logic [31:0] now_ms;
  } bdpc_in_t;

  typedef struct packed {
    logic level_accepted;
    logic stable_level;
    logic press_live;
    logic very_long_hold;
    logic click;
    logic long_press;
    logic very_long_press;
  } bdpc_out_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] stable_count;
    logic [15:0] sample_window;
    logic [15:0] click_min_ms;
    logic [15:0] click_max_ms;
    logic [15:0] long_min_ms;
    logic [15:0] hold_limit_ms;
  } bdpc_cfg_t;

  typedef struct packed {
    logic                 acc;
    logic                 level;
    logic [TIME_BITS-1:0] now;
  } bdpc_qitem_t;

endpackage

// ===== design/bdpc_front.sv =====
// Debounce front end: window tracking and level qualification for each sample.
// Depends on bdpc_pkg; feeds the request queue with the qualified level and time.
module bdpc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bdpc_pkg::bdpc_cfg_t  cfg,
  input  logic                 take,
  input  bdpc_pkg::bdpc_in_t   sample,
  output bdpc_pkg::bdpc_qitem_t item
);
  import bdpc_pkg::*;

  logic        last_sample_r, last_sample_nxt;
  logic [15:0] run_count_r, run_count_nxt;
  logic [15:0] window_index_r, window_index_nxt;
  logic        window_done_r, window_done_nxt;
  logic        acc;

  always_comb begin
    last_sample_nxt  = last_sample_r;
    run_count_nxt    = run_count_r;
    window_index_nxt = window_index_r;
    window_done_nxt  = window_done_r;
    acc              = 1'b0;
    if (cfg.enable) begin
      if (sample.window_start) begin
        last_sample_nxt  = sample.pin_level;
        run_count_nxt    = '0;
        window_index_nxt = '0;
        window_done_nxt  = (cfg.sample_window == '0);
      end else if (!window_done_r) begin
        window_index_nxt = window_index_r + 16'd1;
        if (sample.pin_level == last_sample_r) begin
          if (run_count_r != 16'hFFFF) begin
            run_count_nxt = run_count_r + 16'd1;
          end
        end else begin
          last_sample_nxt = sample.pin_level;
          run_count_nxt   = '0;
        end
        if (run_count_nxt >= cfg.stable_count) begin
          acc             = 1'b1;
          window_done_nxt = 1'b1;
        end else if (window_index_nxt >= cfg.sample_window) begin
          window_done_nxt = 1'b1;
        end
      end
    end
  end

  assign item.acc   = acc;
  assign item.level = sample.pin_level;
  assign item.now   = TIME_BITS'(sample.now_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r  <= 1'b0;
      run_count_r    <= '0;
      window_index_r <= '0;
      window_done_r  <= 1'b1;
    end else if (take) begin
      last_sample_r  <= last_sample_nxt;
      run_count_r    <= run_count_nxt;
      window_index_r <= window_index_nxt;
      window_done_r  <= window_done_nxt;
    end
  end

endmodule

// ===== design/bdpc_queue.sv =====
// Short request queue between the debounce front end and the press tracker.
// Depends on bdpc_pkg for the queued item type.
module bdpc_queue #(
  parameter int DEPTH = bdpc_pkg::BDPC_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bdpc_pkg::bdpc_qitem_t push_item,
  input  logic                  pop,
  output bdpc_pkg::bdpc_qitem_t head,
  output logic                  full,
  output logic                  empty
);
  import bdpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bdpc_qitem_t       mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

// ===== design/bdpc_back.sv =====
// Press tracker back end: holds the accepted level and press timing, classifies releases.
// Depends on bdpc_pkg; drains the request queue into the registered result output.
module bdpc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdpc_pkg::bdpc_cfg_t   cfg,
  input  logic                  q_empty,
  input  bdpc_pkg::bdpc_qitem_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bdpc_pkg::bdpc_out_t   out_data
);
  import bdpc_pkg::*;

  logic                 accepted_level_r, accepted_level_nxt;
  logic                 press_active_r, press_active_nxt;
  logic [TIME_BITS-1:0] press_start_r, press_start_nxt;
  logic                 hold_latched_r, hold_latched_nxt;
  logic                 out_valid_r;
  bdpc_out_t            out_data_r, res;
  logic [TIME_BITS-1:0] dur;
  logic                 starting;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    accepted_level_nxt = accepted_level_r;
    press_active_nxt   = press_active_r;
    press_start_nxt    = press_start_r;
    hold_latched_nxt   = hold_latched_r;
    res                = '0;
    starting           = q_head.acc && !press_active_r && !q_head.level;
    dur                = starting ? '0 : q_head.now - press_start_r;
    if (q_head.acc) begin
      accepted_level_nxt = q_head.level;
      if (starting) begin
        press_active_nxt = 1'b1;
        press_start_nxt  = q_head.now;
      end
      if (press_active_nxt && !q_head.level && !hold_latched_r &&
          dur > TIME_BITS'(cfg.hold_limit_ms)) begin
        res.very_long_hold = 1'b1;
        hold_latched_nxt   = 1'b1;
      end
      if (hold_latched_nxt) begin
        if (q_head.level) begin
          hold_latched_nxt = 1'b0;
          press_active_nxt = 1'b0;
        end
      end else if (press_active_nxt && q_head.level) begin
        if (dur >= TIME_BITS'(cfg.click_min_ms) && dur <= TIME_BITS'(cfg.click_max_ms)) begin
          res.click = 1'b1;
        end else if (dur >= TIME_BITS'(cfg.long_min_ms) &&
                     dur <= TIME_BITS'(cfg.hold_limit_ms)) begin
          res.long_press = 1'b1;
        end else if (dur > TIME_BITS'(cfg.hold_limit_ms)) begin
          res.very_long_press = 1'b1;
        end
        press_active_nxt = 1'b0;
      end
    end
    res.level_accepted = q_head.acc;
    res.stable_level   = accepted_level_nxt;
    res.press_live     = press_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_level_r <= 1'b1;
      press_active_r   <= 1'b0;
      press_start_r    <= '0;
      hold_latched_r   <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (q_pop) begin
        accepted_level_r <= accepted_level_nxt;
        press_active_r   <= press_active_nxt;
        press_start_r    <= press_start_nxt;
        hold_latched_r   <= hold_latched_nxt;
        out_valid_r      <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_data_r.very_long_hold, out_data_r.click,
                              out_data_r.long_press, out_data_r.very_long_press}))
    else $error("more than one event pulse in a result");
  a_pulse_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.very_long_hold || out_data_r.click ||
                     out_data_r.long_press || out_data_r.very_long_press))
    |-> out_data_r.level_accepted)
    else $error("event pulse without an accepted level");
  a_release_ends_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.click || out_data_r.long_press ||
                     out_data_r.very_long_press))
    |-> (!out_data_r.press_live && out_data_r.stable_level))
    else $error("release pulse while press still tracked");
`endif

endmodule

// ===== design/button_debounce_press_classifier.sv =====
// Top level of the button debounce and press classifier: configuration registers and wiring.
// Depends on bdpc_pkg, bdpc_front, bdpc_queue and bdpc_back.
//
//   port group | direction | handshake         | payload
//   in_        | input     | in_valid/in_stall | bdpc_in_t  (pin_level, window_start, now_ms)
//   out_       | output    | out_valid/out_stall | bdpc_out_t (level and event pulses)
//   cfg_       | input     | cfg_valid/cfg_ready | cfg_index (3 bits), cfg_data (16 bits)
//
// One sample is accepted per cycle while the queue is not full; its result passes from the queue
// entry through the output register before it is presented.
// Reset restores config and control registers to documented values and empties the queue.
// in_stall rises only when the FIFO_DEPTH-entry queue is full; out_stall holds the output
// register and lets the queue fill behind it. Configuration writes are always ready.
module button_debounce_press_classifier #(
  parameter int FIFO_DEPTH = bdpc_pkg::BDPC_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bdpc_pkg::bdpc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bdpc_pkg::bdpc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import bdpc_pkg::*;

  bdpc_cfg_t   cfg_r;
  bdpc_qitem_t front_item;
  bdpc_qitem_t q_head;
  logic        take;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= RST_ENABLE;
      cfg_r.stable_count  <= RST_STABLE_COUNT;
      cfg_r.sample_window <= RST_SAMPLE_WINDOW;
      cfg_r.click_min_ms  <= RST_CLICK_MIN_MS;
      cfg_r.click_max_ms  <= RST_CLICK_MAX_MS;
      cfg_r.long_min_ms   <= RST_LONG_MIN_MS;
      cfg_r.hold_limit_ms <= RST_HOLD_LIMIT_MS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:        cfg_r.enable        <= cfg_data[0];
        CFG_STABLE_COUNT:  cfg_r.stable_count  <= cfg_data;
        CFG_SAMPLE_WINDOW: cfg_r.sample_window <= cfg_data;
        CFG_CLICK_MIN_MS:  cfg_r.click_min_ms  <= cfg_data;
        CFG_CLICK_MAX_MS:  cfg_r.click_max_ms  <= cfg_data;
        CFG_LONG_MIN_MS:   cfg_r.long_min_ms   <= cfg_data;
        CFG_HOLD_LIMIT_MS: cfg_r.hold_limit_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  bdpc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .take   (take),
    .sample (in_data),
    .item   (front_item)
  );

  bdpc_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bdpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
